/* design/pts_pkg.sv */
// Shared widths, codes and types of the pre-token segmenter.
package pts_pkg;

    localparam int CP_W   = 21;
    localparam int CLS_W  = 2;
    localparam int LEN_W  = 3;
    localparam int CNT_W  = 16;
    localparam int KIND_W = 3;
    localparam int MDR_W  = 2;

    localparam logic [CNT_W-1:0] MAX_SPAN_COUNT = 16'hFFFF;
    localparam int ADV_STEPS = 7;   // three queued items, two moves each, plus a stall
    localparam int Q_DEPTH   = 3;
    localparam int RES_DEPTH = 4;

    localparam logic [CP_W-1:0] CP_INVALID = 21'h110000;
    localparam logic [CP_W-1:0] CP_SPACE   = 21'h000020;
    localparam logic [CP_W-1:0] CP_CR      = 21'h00000D;
    localparam logic [CP_W-1:0] CP_LF      = 21'h00000A;
    localparam logic [CP_W-1:0] CP_APOS    = 21'h000027;
    localparam logic [CP_W-1:0] CP_UC_A    = 21'h000041;
    localparam logic [CP_W-1:0] CP_UC_Z    = 21'h00005A;
    localparam logic [CP_W-1:0] CP_CASE    = 21'h000020;
    localparam logic [CP_W-1:0] CH_S       = 21'h000073;
    localparam logic [CP_W-1:0] CH_T       = 21'h000074;
    localparam logic [CP_W-1:0] CH_M       = 21'h00006D;
    localparam logic [CP_W-1:0] CH_D       = 21'h000064;
    localparam logic [CP_W-1:0] CH_R       = 21'h000072;
    localparam logic [CP_W-1:0] CH_V       = 21'h000076;
    localparam logic [CP_W-1:0] CH_L       = 21'h00006C;
    localparam logic [CP_W-1:0] CH_E       = 21'h000065;

    localparam logic [2:0] CL_LETTER  = 3'd0;
    localparam logic [2:0] CL_NUMBER  = 3'd1;
    localparam logic [2:0] CL_SPACE   = 3'd2;
    localparam logic [2:0] CL_OTHER   = 3'd3;
    localparam logic [2:0] CL_INVALID = 3'd4;

    localparam logic [KIND_W-1:0] K_CONTR   = 3'd0;
    localparam logic [KIND_W-1:0] K_LETTERS = 3'd1;
    localparam logic [KIND_W-1:0] K_DIGITS  = 3'd2;
    localparam logic [KIND_W-1:0] K_PUNCT   = 3'd3;
    localparam logic [KIND_W-1:0] K_WS      = 3'd4;
    localparam logic [KIND_W-1:0] K_INVALID = 3'd5;

    typedef enum logic [5:0] {
        M_IDLE     = 6'b000001,
        M_LETTERS  = 6'b000010,
        M_DIGITS   = 6'b000100,
        M_PUNCT    = 6'b001000,
        M_PUNCT_NL = 6'b010000,
        M_WS       = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [2:0]       cls;
        logic [LEN_W-1:0] len;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0]  bytes;
        logic [CNT_W-1:0]  cps;
        logic [KIND_W-1:0] kind;
        logic              sat;
        logic              last;
    } t_res;

    typedef struct packed {
        t_mode            mode;
        logic [CNT_W-1:0] span_b;
        logic [CNT_W-1:0] span_c;
        logic             span_sat;
        logic [CNT_W-1:0] brk_b;
        logic [CNT_W-1:0] brk_c;
        logic             brk_sat;
        logic [CNT_W-1:0] tail_b;
        logic [CNT_W-1:0] tail_c;
        logic             tail_sat;
        logic [LEN_W-1:0] fin_len;
        logic             fin_space;
        logic [1:0]       dig;
    } t_st;

    typedef struct packed {
        t_st                        st;
        t_item [Q_DEPTH-1:0]        q;
        logic [1:0]                 n;
        t_res [RES_DEPTH-1:0]       res;
        logic [2:0]                 nres;
        logic                       stop;
    } t_ctx;

endpackage

/* design/pts_if.sv */
// Handshake channels of the pre-token segmenter: items in, spans out, config write.
interface pts_item_if;
    logic                       valid;
    logic                       ready;
    logic [pts_pkg::CP_W-1:0]   codepoint;
    logic [pts_pkg::CLS_W-1:0]  char_class;
    logic [pts_pkg::LEN_W-1:0]  byte_length;
    logic                       end_of_text;
    modport source (output valid, codepoint, char_class, byte_length, end_of_text,
                    input ready);
    modport sink   (input valid, codepoint, char_class, byte_length, end_of_text,
                    output ready);
endinterface

interface pts_span_if;
    logic                        valid;
    logic                        ready;
    logic [pts_pkg::CNT_W-1:0]   span_bytes;
    logic [pts_pkg::CNT_W-1:0]   span_codepoints;
    logic [pts_pkg::KIND_W-1:0]  span_kind;
    logic                        length_saturated;
    logic                        last_of_run;
    modport source (output valid, span_bytes, span_codepoints, span_kind,
                    length_saturated, last_of_run, input ready);
    modport sink   (input valid, span_bytes, span_codepoints, span_kind,
                    length_saturated, last_of_run, output ready);
endinterface

interface pts_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pts_pkg::MDR_W-1:0]  data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* design/pretokenize_segmenter_core.sv */
// Pre-token segmenter: splits a codepoint stream into spans by ordered alternatives.
// Each item is registered on input and processed once the span buffer is free; its spans
//   are registered into the span buffer and shown in order, one per cycle while o_span.ready is high.
// Throughput: one item per cycle while each item closes at most one span and o_span.ready
//   is high; an item that closes several spans holds the span buffer until all (up to four) are taken.
// Reset (i_rst_n low at a clock edge): lookahead emptied, counters cleared, mode idle,
//   digit-run limit back to 3, span buffer empty. No clearing pass.
module pretokenize_segmenter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pts_item_if.sink    i_item,
    pts_span_if.source  o_span,
    pts_cfg_if.sink     i_cfg
);
    import pts_pkg::*;

    // ---------------------------------------------------------------
    // Helpers for one move of the matcher
    // ---------------------------------------------------------------
    function automatic logic [CNT_W:0] f_sat_add(logic [CNT_W-1:0] c, logic [CNT_W-1:0] v);
        logic [CNT_W:0] s;
        s = {1'b0, c} + {1'b0, v};
        if (s[CNT_W]) return {1'b1, MAX_SPAN_COUNT};
        return s;
    endfunction

    function automatic logic f_crlf(logic [CP_W-1:0] cp);
        return (cp == CP_CR) || (cp == CP_LF);
    endfunction

    function automatic logic [CP_W-1:0] f_fold(logic [CP_W-1:0] cp);
        return (cp >= CP_UC_A && cp <= CP_UC_Z) ? cp + CP_CASE : cp;
    endfunction

    function automatic logic [CNT_W-1:0] f_len16(logic [LEN_W-1:0] l);
        return {{(CNT_W-LEN_W){1'b0}}, l};
    endfunction

    function automatic logic [CNT_W-1:0] f_shorten(logic [CNT_W-1:0] v,
                                                   logic [CNT_W-1:0] by, logic sat);
        if (sat && v == MAX_SPAN_COUNT) return v;
        return (v >= by) ? v - by : '0;
    endfunction

    function automatic t_ctx f_emit(t_ctx c, logic [CNT_W-1:0] b, logic [CNT_W-1:0] p,
                                    logic [KIND_W-1:0] k, logic s);
        t_ctx r;
        r = c;
        if (r.nres < 3'd4) begin
            r.res[r.nres[1:0]] = '{bytes: b, cps: p, kind: k, sat: s, last: 1'b0};
            r.nres = r.nres + 3'd1;
        end
        return r;
    endfunction

    function automatic t_ctx f_pop(t_ctx c);
        t_ctx r;
        r = c;
        r.q[0] = r.q[1];
        r.q[1] = r.q[2];
        r.q[2] = '0;
        if (r.n != 2'd0) r.n = r.n - 2'd1;
        return r;
    endfunction

    function automatic t_ctx f_span_add(t_ctx c, t_item it);
        t_ctx r;
        logic [CNT_W:0] s;
        r = c;
        s = f_sat_add(r.st.span_b, f_len16(it.len));
        r.st.span_b = s[CNT_W-1:0];
        r.st.span_sat = r.st.span_sat | s[CNT_W];
        s = f_sat_add(r.st.span_c, 16'd1);
        r.st.span_c = s[CNT_W-1:0];
        r.st.span_sat = r.st.span_sat | s[CNT_W];
        return r;
    endfunction

    function automatic t_ctx f_span_close(t_ctx c, logic [KIND_W-1:0] k);
        t_ctx r;
        r = f_emit(c, c.st.span_b, c.st.span_c, k, c.st.span_sat);
        r.st.span_b = '0;
        r.st.span_c = '0;
        r.st.span_sat = 1'b0;
        r.st.dig = 2'd0;
        r.st.mode = M_IDLE;
        return r;
    endfunction

    function automatic t_ctx f_ws_add(t_ctx c, t_item it);
        t_ctx r;
        logic [CNT_W:0] s;
        r = c;
        if (f_crlf(it.cp)) begin
            // a line break absorbs the pending tail
            s = f_sat_add(r.st.brk_b, r.st.tail_b);
            r.st.brk_b = s[CNT_W-1:0];
            r.st.brk_sat = r.st.brk_sat | s[CNT_W];
            s = f_sat_add(r.st.brk_c, r.st.tail_c);
            r.st.brk_c = s[CNT_W-1:0];
            r.st.brk_sat = r.st.brk_sat | s[CNT_W] | r.st.tail_sat;
            s = f_sat_add(r.st.brk_b, f_len16(it.len));
            r.st.brk_b = s[CNT_W-1:0];
            r.st.brk_sat = r.st.brk_sat | s[CNT_W];
            s = f_sat_add(r.st.brk_c, 16'd1);
            r.st.brk_c = s[CNT_W-1:0];
            r.st.brk_sat = r.st.brk_sat | s[CNT_W];
            r.st.tail_b = '0;
            r.st.tail_c = '0;
            r.st.tail_sat = 1'b0;
        end else begin
            s = f_sat_add(r.st.tail_b, f_len16(it.len));
            r.st.tail_b = s[CNT_W-1:0];
            r.st.tail_sat = r.st.tail_sat | s[CNT_W];
            s = f_sat_add(r.st.tail_c, 16'd1);
            r.st.tail_c = s[CNT_W-1:0];
            r.st.tail_sat = r.st.tail_sat | s[CNT_W];
        end
        r.st.fin_len = it.len;
        r.st.fin_space = (it.cp == CP_SPACE);
        return r;
    endfunction

    function automatic t_ctx f_ws_resolve(t_ctx c, logic has_next, t_item nx);
        t_ctx r;
        r = c;
        r.st.mode = M_IDLE;
        if (r.st.brk_c != '0) r = f_emit(r, r.st.brk_b, r.st.brk_c, K_WS, r.st.brk_sat);
        if (r.st.tail_c != '0) begin
            if (!has_next) begin
                r = f_emit(r, r.st.tail_b, r.st.tail_c, K_WS, r.st.tail_sat);
            end else begin
                // last whitespace codepoint is split off: it starts the next span or is a span of its own
                if (r.st.tail_c > 16'd1)
                    r = f_emit(r, f_shorten(r.st.tail_b, f_len16(r.st.fin_len), r.st.tail_sat),
                               f_shorten(r.st.tail_c, 16'd1, r.st.tail_sat),
                               K_WS, r.st.tail_sat);
                r.st.span_b = f_len16(r.st.fin_len);
                r.st.span_c = 16'd1;
                r.st.span_sat = 1'b0;
                if (nx.cls == CL_LETTER) r.st.mode = M_LETTERS;
                else if (r.st.fin_space && nx.cls == CL_OTHER) r.st.mode = M_PUNCT;
                else r = f_span_close(r, K_WS);
            end
        end
        r.st.brk_b = '0;
        r.st.brk_c = '0;
        r.st.brk_sat = 1'b0;
        r.st.tail_b = '0;
        r.st.tail_c = '0;
        r.st.tail_sat = 1'b0;
        r.st.fin_len = '0;
        r.st.fin_space = 1'b0;
        return r;
    endfunction

    function automatic t_ctx f_start(t_ctx c, logic eot, logic [1:0] lim);
        t_ctx r;
        t_item h;
        logic [CP_W-1:0] s1;
        logic [CP_W-1:0] s2;
        r = c;
        h = r.q[0];
        s1 = f_fold(r.q[1].cp);
        s2 = f_fold(r.q[2].cp);
        if (h.cls == CL_INVALID) begin
            r = f_emit(r, f_len16(h.len), 16'd1, K_INVALID, 1'b0);
            return f_pop(r);
        end
        if (h.cp == CP_APOS && h.cls == CL_OTHER) begin
            if (r.n < 2'd2 && !eot) begin
                r.stop = 1'b1;
                return r;
            end
            if (r.n >= 2'd2) begin
                if (s1 == CH_S || s1 == CH_T || s1 == CH_M || s1 == CH_D) begin
                    r = f_emit(r, f_len16(h.len) + f_len16(r.q[1].len), 16'd2,
                               K_CONTR, 1'b0);
                    return f_pop(f_pop(r));
                end
                if (s1 == CH_R || s1 == CH_V || s1 == CH_L) begin
                    if (r.n < 2'd3 && !eot) begin
                        r.stop = 1'b1;
                        return r;
                    end
                    if (r.n == 2'd3 && (((s1 == CH_R || s1 == CH_V) && s2 == CH_E) ||
                                        (s1 == CH_L && s2 == CH_L))) begin
                        r = f_emit(r, f_len16(h.len) + f_len16(r.q[1].len) +
                                   f_len16(r.q[2].len), 16'd3, K_CONTR, 1'b0);
                        return f_pop(f_pop(f_pop(r)));
                    end
                end
            end
        end
        if (h.cls == CL_LETTER) begin
            r = f_span_add(r, h);
            r.st.mode = M_LETTERS;
            return f_pop(r);
        end
        // one-codepoint prefix before a letter run
        if (h.cls != CL_NUMBER && !f_crlf(h.cp)) begin
            if (r.n < 2'd2 && !eot) begin
                r.stop = 1'b1;
                return r;
            end
            if (r.n >= 2'd2 && r.q[1].cls == CL_LETTER) begin
                r = f_span_add(r, h);
                r.st.mode = M_LETTERS;
                return f_pop(r);
            end
        end
        if (h.cls == CL_NUMBER) begin
            r = f_span_add(r, h);
            r.st.dig = 2'd1;
            r.st.mode = M_DIGITS;
            if (lim == 2'd1) r = f_span_close(r, K_DIGITS);
        end else if (h.cls == CL_OTHER ||
                     (h.cp == CP_SPACE && r.n >= 2'd2 && r.q[1].cls == CL_OTHER)) begin
            r = f_span_add(r, h);
            r.st.mode = M_PUNCT;
        end else begin
            r = f_ws_add(r, h);
            r.st.mode = M_WS;
        end
        return f_pop(r);
    endfunction

    function automatic t_ctx f_advance(t_ctx c, logic eot, logic [1:0] lim);
        t_ctx r;
        t_item h;
        r = c;
        h = r.q[0];
        if (r.stop || r.n == 2'd0) return r;
        unique case (r.st.mode)
            M_LETTERS: begin
                if (h.cls == CL_LETTER) r = f_pop(f_span_add(r, h));
                else r = f_span_close(r, K_LETTERS);
            end
            M_DIGITS: begin
                if (h.cls == CL_NUMBER && r.st.dig < lim) begin
                    r = f_pop(f_span_add(r, h));
                    r.st.dig = r.st.dig + 2'd1;
                    if (r.st.dig >= lim) r = f_span_close(r, K_DIGITS);
                end else begin
                    r = f_span_close(r, K_DIGITS);
                end
            end
            M_PUNCT: begin
                if (h.cls == CL_OTHER) begin
                    r = f_pop(f_span_add(r, h));
                end else if (f_crlf(h.cp)) begin
                    r = f_pop(f_span_add(r, h));
                    r.st.mode = M_PUNCT_NL;
                end else begin
                    r = f_span_close(r, K_PUNCT);
                end
            end
            M_PUNCT_NL: begin
                if (f_crlf(h.cp)) r = f_pop(f_span_add(r, h));
                else r = f_span_close(r, K_PUNCT);
            end
            M_WS: begin
                if (h.cls == CL_SPACE) r = f_pop(f_ws_add(r, h));
                else r = f_ws_resolve(r, 1'b1, h);
            end
            M_IDLE: r = f_start(r, eot, lim);
            default: r = f_start(r, eot, lim);
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic [MDR_W-1:0] r_max_digit;
    logic             r_in_v;
    t_item            r_in;
    logic             r_in_eot;
    t_st              r_st;
    t_item [1:0]      r_slot;
    logic [1:0]       r_slot_cnt;
    t_res [RES_DEPTH-1:0] r_res;
    logic [2:0]       r_res_cnt;
    logic [2:0]       r_res_rd;

    t_st              n_st;
    t_item [1:0]      n_slot;
    logic [1:0]       n_slot_cnt;
    t_res [RES_DEPTH-1:0] n_res;
    logic [2:0]       n_res_cnt;
    t_item            n_in;

    logic out_fire, buf_free, proc, in_fire;

    // input normalization: out-of-range codepoints are invalid, lengths clamped to 1..4
    always_comb begin
        n_in.cp = i_item.codepoint;
        n_in.cls = (i_item.codepoint >= CP_INVALID) ? CL_INVALID : {1'b0, i_item.char_class};
        if (i_item.byte_length == 3'd0) n_in.len = 3'd1;
        else if (i_item.byte_length > 3'd4) n_in.len = 3'd4;
        else n_in.len = i_item.byte_length;
    end

    // span buffer handshake; an item is processed once the buffer drains
    assign o_span.valid = (r_res_rd != r_res_cnt);
    assign out_fire     = o_span.valid && o_span.ready;
    assign buf_free     = !o_span.valid || (out_fire && (r_res_rd + 3'd1 == r_res_cnt));
    assign proc         = r_in_v && buf_free;
    assign i_item.ready = !r_in_v || proc;
    assign in_fire      = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    assign o_span.span_bytes       = r_res[r_res_rd[1:0]].bytes;
    assign o_span.span_codepoints  = r_res[r_res_rd[1:0]].cps;
    assign o_span.span_kind        = r_res[r_res_rd[1:0]].kind;
    assign o_span.length_saturated = r_res[r_res_rd[1:0]].sat;
    assign o_span.last_of_run      = r_res[r_res_rd[1:0]].last;

    // one full step: queue = lookahead + new item, matcher runs until it stalls
    always_comb begin
        t_ctx c;
        logic [1:0] lim;
        logic [2:0] lastix;
        lim = (r_max_digit == 2'd0) ? 2'd1 : r_max_digit;
        c = '0;
        c.st = r_st;
        c.q[0] = r_slot[0];
        c.q[1] = r_slot[1];
        c.q[r_slot_cnt] = r_in;
        c.n = r_slot_cnt + 2'd1;
        for (int i = 0; i < ADV_STEPS; i++) c = f_advance(c, r_in_eot, lim);
        if (r_in_eot) begin
            // end of text closes whatever is open
            unique case (c.st.mode)
                M_LETTERS:  c = f_span_close(c, K_LETTERS);
                M_DIGITS:   c = f_span_close(c, K_DIGITS);
                M_PUNCT:    c = f_span_close(c, K_PUNCT);
                M_PUNCT_NL: c = f_span_close(c, K_PUNCT);
                M_WS:       c = f_ws_resolve(c, 1'b0, '0);
                M_IDLE:     c = c;
                default:    c = c;
            endcase
            c.st.mode = M_IDLE;
            c.n = 2'd0;
        end
        lastix = c.nres - 3'd1;
        if (c.nres != 3'd0) c.res[lastix[1:0]].last = 1'b1;
        n_st = c.st;
        n_slot[0] = c.q[0];
        n_slot[1] = c.q[1];
        n_slot_cnt = (c.n > 2'd2) ? 2'd2 : c.n;
        n_res = c.res;
        n_res_cnt = c.nres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_digit <= 2'd3;
            r_in_v <= 1'b0;
            r_st <= '{mode: M_IDLE, default: '0};
            r_slot_cnt <= 2'd0;
            r_res_cnt <= 3'd0;
            r_res_rd <= 3'd0;
        end else begin
            if (i_cfg.valid) r_max_digit <= i_cfg.data;
            if (in_fire) r_in_v <= 1'b1;
            else if (proc) r_in_v <= 1'b0;
            if (proc) begin
                r_st <= n_st;
                r_slot_cnt <= n_slot_cnt;
                r_res_cnt <= n_res_cnt;
                r_res_rd <= 3'd0;
            end else if (out_fire) begin
                r_res_rd <= r_res_rd + 3'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= n_in;
            r_in_eot <= i_item.end_of_text;
        end
        if (proc) begin
            r_slot <= n_slot;
            r_res <= n_res;
        end
    end

endmodule
